### rtl/wat_pkg.sv
`timescale 1ns / 1ps
package wat_pkg;

   // waypoint loop
   localparam int MAX_WAYPOINTS = 4;
   localparam int CORDIC_ITERATIONS = 32;

   // configuration port
   localparam int ADDR_W = 6;
   localparam int CSR_W = 64;
   localparam logic [2:0] REG_WAYPOINT_ZERO = 3'd0;
   localparam logic [2:0] REG_WAYPOINT_ONE = 3'd1;
   localparam logic [2:0] REG_WAYPOINT_TWO = 3'd2;
   localparam logic [2:0] REG_WAYPOINT_THREE = 3'd3;
   localparam logic [2:0] REG_ACTIVE_WAYPOINTS = 3'd4;
   localparam logic [2:0] REG_ARRIVAL_RADIUS = 3'd5;

   // angle slots worked through for each request
   localparam logic [1:0] ANG_DLAT = 2'd0;
   localparam logic [1:0] ANG_DLON = 2'd1;
   localparam logic [1:0] ANG_LAT1 = 2'd2;
   localparam logic [1:0] ANG_LAT2 = 2'd3;

   // datapath widths
   localparam int ANG_W = 35;
   localparam int CW = 34;
   localparam int MUL_A_W = 61;
   localparam int MUL_B_W = 31;
   localparam int PROD_W = MUL_A_W + MUL_B_W + 1;
   localparam int QUOT_W = 31;
   localparam int ROOT_W = 31;
   localparam int SREM_W = 34;
   localparam int DIST_W = 35;

   // fixed-point constants
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint ONE_Q60 = 64'sd1152921504606846976;
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint CORDIC_START = 64'sd652032874;
   localparam longint QUARTER_TURN = 64'sd1800000000;
   localparam longint HALF_TURN = 64'sd3600000000;
   localparam longint FULL_TURN = 64'sd7200000000;
   localparam longint RADIUS_MM = 64'sd6371000000;
   localparam longint ROUND_HALF = 64'sd268435456;

   typedef struct packed {
      logic signed [31:0] fix_latitude;
      logic signed [31:0] fix_longitude;
   } wat_req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance_mm;
      logic              arrived;
      logic [1:0]        target_before;
      logic [1:0]        target_after;
   } wat_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ANG_LOAD,
      ST_ANG_WRAP,
      ST_ANG_FOLD,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ROT_LOAD,
      ST_CORDIC,
      ST_ANG_SAVE,
      ST_C12,
      ST_B,
      ST_T2,
      ST_S1,
      ST_SUM_A,
      ST_SQRT,
      ST_SQRT_Y,
      ST_VEC_LOAD,
      ST_ZCLAMP,
      ST_DIST_ADD,
      ST_DONE
   } wat_state_type;

   // arctangent of 2^-i in Q2.30
   function automatic logic [31:0] atan_q30(input logic [5:0] i);
      logic [31:0] v;
      case (i)
         6'd0:    v = 32'd843314857;
         6'd1:    v = 32'd497837829;
         6'd2:    v = 32'd263043837;
         6'd3:    v = 32'd133525159;
         6'd4:    v = 32'd67021687;
         6'd5:    v = 32'd33543516;
         6'd6:    v = 32'd16775851;
         6'd7:    v = 32'd8388437;
         6'd8:    v = 32'd4194283;
         6'd9:    v = 32'd2097149;
         6'd10:   v = 32'd1048576;
         6'd11:   v = 32'd524288;
         default: begin
            if (i <= 6'd30) v = 32'd1 << (6'd30 - i);
            else v = 32'd0;
         end
      endcase
      return v;
   endfunction

endpackage

### rtl/waypoint_arrival_tracker_top.sv
`timescale 1ns / 1ps
// Channel  | Ports                                  | Direction
// req      | req_valid, req_stall, req_data         | fix in
// rsp      | rsp_valid, rsp_stall, rsp_data         | distance/arrival out
// csr      | csr_psel/penable/pwrite/paddr/pwdata,  | register access,
//          | csr_prdata, csr_pready                 | 8-byte stride
//
// One request at a time. Each of the four angles takes a serial multiply, a
// serial divide and CORDIC_ITERATIONS CORDIC steps; then come four serial
// multiplies, two square roots, one vectoring CORDIC and a final multiply
// before the next request can be accepted.
// Reset is synchronous: target index 0, registers to their documented values.
// A finished response waits in the output register while the next request is
// taken; the sequencer only holds in its last state on a full, stalled register.
module waypoint_arrival_tracker_top #(
   parameter int CORDIC_ITERATIONS = wat_pkg::CORDIC_ITERATIONS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  wat_pkg::wat_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output wat_pkg::wat_rsp_type        rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wat_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [wat_pkg::CSR_W-1:0]   csr_pwdata,
   output logic [wat_pkg::CSR_W-1:0]   csr_prdata,
   output logic                        csr_pready
);
   import wat_pkg::*;

   localparam int CNT_W = $clog2(CORDIC_ITERATIONS > 32 ? CORDIC_ITERATIONS : 32);

   localparam logic signed [ANG_W-1:0] HT_S = ANG_W'(HALF_TURN);
   localparam logic signed [ANG_W-1:0] FT_S = ANG_W'(FULL_TURN);
   localparam logic signed [ANG_W-1:0] QT_S = ANG_W'(QUARTER_TURN);
   localparam logic signed [CW-1:0] ONE_C = CW'(ONE_Q30);
   localparam logic signed [CW-1:0] HALF_PI_C = CW'(HALF_PI_Q30);

   // sequencer
   wat_state_type state_ff, state_in, ret_ff, ret_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] ang_ff, ang_in;

   // captured request and target
   logic signed [31:0] lat1_ff, lat1_in, lon1_ff, lon1_in;
   logic signed [31:0] lat2_ff, lat2_in, lon2_ff, lon2_in;
   logic [1:0] before_ff, before_in;
   logic [1:0] target_ff, target_in;

   // angle reduction
   logic signed [ANG_W-1:0] h_ff, h_in;
   logic negcos_ff, negcos_in, hneg_ff, hneg_in;

   // shift-add multiplier: hi accumulates, lo holds the multiplier bits
   logic [MUL_A_W-1:0] mul_a_ff, mul_a_in;
   logic [MUL_A_W:0] hi_ff, hi_in;
   logic [MUL_B_W-1:0] lo_ff, lo_in;

   // restoring divider by the half turn
   logic [31:0] rem_ff, rem_in;
   logic [QUOT_W-1:0] dq_ff, dq_in;

   // CORDIC
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic vec_ff, vec_in;

   // trig results and haversine terms
   logic [30:0] s1m_ff, s1m_in, s2m_ff, s2m_in, c1m_ff, c1m_in, c2m_ff, c2m_in;
   logic c1neg_ff, c1neg_in, c2neg_ff, c2neg_in;
   logic [60:0] t2_ff, t2_in, a_ff, a_in;

   // digit-by-digit square root, two bits per cycle
   logic [61:0] v_ff, v_in;
   logic [SREM_W-1:0] srem_ff, srem_in;
   logic [ROOT_W-1:0] root_ff, root_in, ty_ff, ty_in;

   // result
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic arrived_ff, arrived_in;
   logic rsp_valid_ff, rsp_valid_in;
   wat_rsp_type rsp_data_ff, rsp_data_in;

   // registers
   logic [63:0] wp0_ff, wp0_in, wp1_ff, wp1_in, wp2_ff, wp2_in, wp3_ff, wp3_in;
   logic [2:0] active_ff, active_in;
   logic [15:0] radius_ff, radius_in;

   // ---------------- datapath arithmetic ----------------
   logic csr_wr;
   logic [2:0] csr_idx;
   logic [63:0] wp_sel;
   logic signed [ANG_W-1:0] h_sel, h_wrap, h_fold;
   logic [30:0] h_mag;
   logic [MUL_A_W:0] mul_sum;
   logic [PROD_W-1:0] prod_w;
   logic [62:0] div_num;
   logic [32:0] div_trial;
   logic div_ge;
   logic signed [CW-1:0] dx, dy, atan_s, x_c, y_c, x_abs, y_abs;
   logic cor_pos, cor_hold;
   logic signed [62:0] a_sum;
   logic [60:0] a_clamp;
   logic [SREM_W+1:0] srem_sh, strial;
   logic sq_ge;
   logic [30:0] z_clamp;
   logic [63:0] dist_sum;
   logic [DIST_W-1:0] dist_val;
   logic [2:0] count_lim, before_inc;
   logic [1:0] target_next;

   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx = csr_paddr[5:3];
   assign csr_pready = 1'b1;

   always_comb begin
      case (target_ff)
         2'd0:    wp_sel = wp0_ff;
         2'd1:    wp_sel = wp1_ff;
         2'd2:    wp_sel = wp2_ff;
         default: wp_sel = wp3_ff;
      endcase
   end

   always_comb begin
      case (csr_idx)
         REG_WAYPOINT_ZERO:    csr_prdata = wp0_ff;
         REG_WAYPOINT_ONE:     csr_prdata = wp1_ff;
         REG_WAYPOINT_TWO:     csr_prdata = wp2_ff;
         REG_WAYPOINT_THREE:   csr_prdata = wp3_ff;
         REG_ACTIVE_WAYPOINTS: csr_prdata = {61'd0, active_ff};
         REG_ARRIVAL_RADIUS:   csr_prdata = {48'd0, radius_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // angles in half units (5e-8 degree)
   always_comb begin
      case (ang_ff)
         ANG_DLAT: h_sel = ANG_W'(lat2_ff) - ANG_W'(lat1_ff);
         ANG_DLON: h_sel = ANG_W'(lon2_ff) - ANG_W'(lon1_ff);
         ANG_LAT1: h_sel = ANG_W'(lat1_ff) <<< 1;
         default:  h_sel = ANG_W'(lat2_ff) <<< 1;
      endcase
   end

   assign h_wrap = (h_ff > HT_S) ? h_ff - FT_S : ((h_ff < -HT_S) ? h_ff + FT_S : h_ff);
   // fold into +-90 degrees; either fold flips the cosine
   assign h_fold = (h_ff > QT_S) ? HT_S - h_ff : ((h_ff < -QT_S) ? -HT_S - h_ff : h_ff);
   assign h_mag = h_fold[ANG_W-1] ? 31'(-h_fold) : h_fold[30:0];

   assign mul_sum = hi_ff + (lo_ff[0] ? {1'b0, mul_a_ff} : '0);
   assign prod_w = {hi_ff, lo_ff};

   assign div_num = prod_w[62:0] + 63'(QUARTER_TURN);
   assign div_trial = {rem_ff, dq_ff[QUOT_W-1]};
   assign div_ge = div_trial >= 33'(HALF_TURN);

   assign dx = x_ff >>> cnt_ff;
   assign dy = y_ff >>> cnt_ff;
   assign atan_s = CW'(signed'({1'b0, atan_q30(6'(cnt_ff))}));
   // rotation steers by the residual angle, vectoring drives y to zero
   assign cor_pos = vec_ff ? y_ff[CW-1] : ~z_ff[CW-1];
   assign cor_hold = vec_ff && (y_ff == '0);

   assign x_c = (x_ff > ONE_C) ? ONE_C : ((x_ff < -ONE_C) ? -ONE_C : x_ff);
   assign y_c = (y_ff > ONE_C) ? ONE_C : ((y_ff < -ONE_C) ? -ONE_C : y_ff);
   assign x_abs = x_c[CW-1] ? -x_c : x_c;
   assign y_abs = y_c[CW-1] ? -y_c : y_c;

   assign a_sum = (c1neg_ff ^ c2neg_ff) ? signed'({2'b00, prod_w[60:0]}) - signed'({2'b00, t2_ff})
                                        : signed'({2'b00, prod_w[60:0]}) + signed'({2'b00, t2_ff});
   assign a_clamp = a_sum[62] ? '0 : ((a_sum > 63'(ONE_Q60)) ? 61'(ONE_Q60) : a_sum[60:0]);

   assign srem_sh = {srem_ff, v_ff[61:60]};
   assign strial = {3'b000, root_ff, 2'b01};
   assign sq_ge = srem_sh >= strial;

   assign z_clamp = z_ff[CW-1] ? '0 : ((z_ff > HALF_PI_C) ? 31'(HALF_PI_Q30) : z_ff[30:0]);

   // R * 2 * theta with theta in Q30, rounded half up
   assign dist_sum = prod_w[63:0] + 64'(ROUND_HALF);
   assign dist_val = dist_sum[63:29];

   assign count_lim = (active_ff == 3'd0) ? 3'd1
                    : ((active_ff > 3'(MAX_WAYPOINTS)) ? 3'(MAX_WAYPOINTS) : active_ff);
   assign before_inc = {1'b0, before_ff} + 3'd1;
   assign target_next = (before_inc >= count_lim) ? 2'd0 : before_inc[1:0];

   // ---------------- sequencer and next values ----------------
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      cnt_in = cnt_ff;
      ang_in = ang_ff;
      lat1_in = lat1_ff;
      lon1_in = lon1_ff;
      lat2_in = lat2_ff;
      lon2_in = lon2_ff;
      before_in = before_ff;
      target_in = target_ff;
      h_in = h_ff;
      negcos_in = negcos_ff;
      hneg_in = hneg_ff;
      mul_a_in = mul_a_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      rem_in = rem_ff;
      dq_in = dq_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      vec_in = vec_ff;
      s1m_in = s1m_ff;
      s2m_in = s2m_ff;
      c1m_in = c1m_ff;
      c2m_in = c2m_ff;
      c1neg_in = c1neg_ff;
      c2neg_in = c2neg_ff;
      t2_in = t2_ff;
      a_in = a_ff;
      v_in = v_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      ty_in = ty_ff;
      dist_in = dist_ff;
      arrived_in = arrived_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in = rsp_data_ff;
      req_stall = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lat1_in = req_data.fix_latitude;
               lon1_in = req_data.fix_longitude;
               lat2_in = wp_sel[63:32];
               lon2_in = wp_sel[31:0];
               before_in = target_ff;
               ang_in = ANG_DLAT;
               state_in = ST_ANG_LOAD;
            end
         end
         ST_ANG_LOAD: begin
            h_in = h_sel;
            state_in = ST_ANG_WRAP;
         end
         ST_ANG_WRAP: begin
            h_in = h_wrap;
            state_in = ST_ANG_FOLD;
         end
         ST_ANG_FOLD: begin
            negcos_in = (h_ff > QT_S) || (h_ff < -QT_S);
            hneg_in = h_fold[ANG_W-1];
            mul_a_in = MUL_A_W'(PI_Q30);
            hi_in = '0;
            lo_in = h_mag;
            cnt_in = '0;
            ret_in = ST_DIV_LOAD;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            hi_in = {1'b0, mul_sum[MUL_A_W:1]};
            lo_in = {mul_sum[0], lo_ff[MUL_B_W-1:1]};
            if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
               cnt_in = '0;
               state_in = ret_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_LOAD: begin
            // quotient fits 31 bits, so the top of the numerator is already below the divisor
            rem_in = div_num[62:31];
            dq_in = div_num[30:0];
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? 32'(div_trial - 33'(HALF_TURN)) : div_trial[31:0];
            dq_in = {dq_ff[QUOT_W-2:0], div_ge};
            if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
               cnt_in = '0;
               state_in = ST_ROT_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROT_LOAD: begin
            x_in = CW'(CORDIC_START);
            y_in = '0;
            z_in = hneg_ff ? -CW'({1'b0, dq_ff}) : CW'({1'b0, dq_ff});
            vec_in = 1'b0;
            cnt_in = '0;
            ret_in = ST_ANG_SAVE;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (!cor_hold) begin
               if (cor_pos) begin
                  x_in = x_ff - dy;
                  y_in = y_ff + dx;
                  z_in = z_ff - atan_s;
               end else begin
                  x_in = x_ff + dy;
                  y_in = y_ff - dx;
                  z_in = z_ff + atan_s;
               end
            end
            if (cnt_ff == CNT_W'(CORDIC_ITERATIONS - 1)) begin
               cnt_in = '0;
               state_in = ret_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ANG_SAVE: begin
            case (ang_ff)
               ANG_DLAT: s1m_in = y_abs[30:0];
               ANG_DLON: s2m_in = y_abs[30:0];
               ANG_LAT1: begin
                  c1m_in = x_abs[30:0];
                  c1neg_in = negcos_ff ? (x_c > 0) : x_c[CW-1];
               end
               default: begin
                  c2m_in = x_abs[30:0];
                  c2neg_in = negcos_ff ? (x_c > 0) : x_c[CW-1];
               end
            endcase
            if (ang_ff == ANG_LAT2) begin
               state_in = ST_C12;
            end else begin
               ang_in = ang_ff + 2'd1;
               state_in = ST_ANG_LOAD;
            end
         end
         ST_C12: begin
            mul_a_in = MUL_A_W'(c1m_ff);
            hi_in = '0;
            lo_in = c2m_ff;
            ret_in = ST_B;
            state_in = ST_MUL;
         end
         ST_B: begin
            // cos1*cos2 in Q30
            mul_a_in = MUL_A_W'(prod_w[60:30]);
            hi_in = '0;
            lo_in = s2m_ff;
            ret_in = ST_T2;
            state_in = ST_MUL;
         end
         ST_T2: begin
            mul_a_in = prod_w[60:0];
            hi_in = '0;
            lo_in = s2m_ff;
            ret_in = ST_S1;
            state_in = ST_MUL;
         end
         ST_S1: begin
            t2_in = prod_w[90:30];
            mul_a_in = MUL_A_W'(s1m_ff);
            hi_in = '0;
            lo_in = s1m_ff;
            ret_in = ST_SUM_A;
            state_in = ST_MUL;
         end
         ST_SUM_A: begin
            a_in = a_clamp;
            v_in = {1'b0, a_clamp};
            srem_in = '0;
            root_in = '0;
            cnt_in = '0;
            ret_in = ST_SQRT_Y;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            srem_in = sq_ge ? SREM_W'(srem_sh - strial) : srem_sh[SREM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
            v_in = {v_ff[59:0], 2'b00};
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               cnt_in = '0;
               state_in = ret_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SQRT_Y: begin
            ty_in = root_ff;
            v_in = {1'b0, 61'(ONE_Q60) - a_ff};
            srem_in = '0;
            root_in = '0;
            cnt_in = '0;
            ret_in = ST_VEC_LOAD;
            state_in = ST_SQRT;
         end
         ST_VEC_LOAD: begin
            x_in = CW'({1'b0, root_ff});
            y_in = CW'({1'b0, ty_ff});
            z_in = '0;
            vec_in = 1'b1;
            cnt_in = '0;
            ret_in = ST_ZCLAMP;
            state_in = ST_CORDIC;
         end
         ST_ZCLAMP: begin
            mul_a_in = MUL_A_W'(RADIUS_MM);
            hi_in = '0;
            lo_in = z_clamp;
            ret_in = ST_DIST_ADD;
            state_in = ST_MUL;
         end
         ST_DIST_ADD: begin
            dist_in = dist_val;
            arrived_in = dist_val <= DIST_W'(radius_ff);
            if (dist_val <= DIST_W'(radius_ff)) target_in = target_next;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.distance_mm = dist_ff;
               rsp_data_in.arrived = arrived_ff;
               rsp_data_in.target_before = before_ff;
               rsp_data_in.target_after = target_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // register writes
   always_comb begin
      wp0_in = wp0_ff;
      wp1_in = wp1_ff;
      wp2_in = wp2_ff;
      wp3_in = wp3_ff;
      active_in = active_ff;
      radius_in = radius_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_WAYPOINT_ZERO:    wp0_in = csr_pwdata;
            REG_WAYPOINT_ONE:     wp1_in = csr_pwdata;
            REG_WAYPOINT_TWO:     wp2_in = csr_pwdata;
            REG_WAYPOINT_THREE:   wp3_in = csr_pwdata;
            REG_ACTIVE_WAYPOINTS: active_in = csr_pwdata[2:0];
            REG_ARRIVAL_RADIUS:   radius_in = csr_pwdata[15:0];
            default:              ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         cnt_ff <= '0;
         target_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
         wp0_ff <= '0;
         wp1_ff <= '0;
         wp2_ff <= '0;
         wp3_ff <= '0;
         active_ff <= 3'd4;
         radius_ff <= 16'd500;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         cnt_ff <= cnt_in;
         target_ff <= target_in;
         rsp_valid_ff <= rsp_valid_in;
         wp0_ff <= wp0_in;
         wp1_ff <= wp1_in;
         wp2_ff <= wp2_in;
         wp3_ff <= wp3_in;
         active_ff <= active_in;
         radius_ff <= radius_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff <= ang_in;
      lat1_ff <= lat1_in;
      lon1_ff <= lon1_in;
      lat2_ff <= lat2_in;
      lon2_ff <= lon2_in;
      before_ff <= before_in;
      h_ff <= h_in;
      negcos_ff <= negcos_in;
      hneg_ff <= hneg_in;
      mul_a_ff <= mul_a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      rem_ff <= rem_in;
      dq_ff <= dq_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      vec_ff <= vec_in;
      s1m_ff <= s1m_in;
      s2m_ff <= s2m_in;
      c1m_ff <= c1m_in;
      c2m_ff <= c2m_in;
      c1neg_ff <= c1neg_in;
      c2neg_ff <= c2neg_in;
      t2_ff <= t2_in;
      a_ff <= a_in;
      v_ff <= v_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      ty_ff <= ty_in;
      dist_ff <= dist_in;
      arrived_ff <= arrived_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // target moves only when a distance is resolved
   a_target_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIST_ADD) |=> $stable(target_ff))
      else $error("target index changed outside distance resolve");

   a_no_arrive_same: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.arrived) |-> (rsp_data.target_after == rsp_data.target_before))
      else $error("target advanced without arrival");

   a_arrive_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.arrived) |-> (rsp_data.distance_mm <= DIST_W'(radius_ff)))
      else $error("arrival flagged beyond radius");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT_Y) |-> (root_ff <= ROOT_W'(ONE_Q30)))
      else $error("square root above one");

endmodule

### tb/sv/waypoint_arrival_tracker_top_tb.sv
`timescale 1ns / 1ps
module waypoint_arrival_tracker_top_tb;
   import wat_pkg::*;

   localparam int CLK_HALF = 6;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 1700;
   localparam int PHASES = 8;
   localparam int QUIET_TAIL = 150;       // last requests go without idling
   localparam int HOLD_CYCLES = 3000;     // long receiver hold-off
   localparam int DRAIN_CYCLES = 1000;    // idle time after the last response
   localparam longint CYCLE_LIMIT = 64'd8000000;
   localparam logic [2:0] REG_UNMAPPED = 3'd6;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   wat_req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   wat_rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [CSR_W-1:0] csr_pwdata;
   logic [CSR_W-1:0] csr_prdata;
   logic csr_pready;

   waypoint_arrival_tracker_top uut (.*);

   // shadow of the block: registers and target index
   logic [63:0] waypoint_reg [4];
   logic [2:0]  loop_len;
   logic [15:0] radius_mm;
   logic [1:0]  nav_target;

   wat_rsp_type leg_reports [$];   // expected responses, oldest first
   int mismatches = 0;
   int reports_seen = 0;
   int arrivals_seen = 0;
   int sent = 0;
   bit quiet_tail = 0;
   bit hold_pending = 0;
   longint cycles = 0;

   typedef struct {
      logic signed [31:0] lat;
      logic signed [31:0] lon;
      bit known;          // arrival/target fields typed in below
      bit arr;
      logic [1:0] bef;
      logic [1:0] aft;
   } fix_row_type;

   fix_row_type fix_rows [14];

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic longint arctan_step(input int i);
      longint head [12] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149,
                            1048576, 524288};
      if (i < 12) return head[i];
      if (i <= 30) return longint'(1) << (30 - i);
      return 0;
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint unsigned mul_q30(input longint unsigned u,
                                               input longint unsigned s);
      return (u >> 30) * s + (((u & 64'h3FFFFFFF) * s) >> 30);
   endfunction

   // sine and cosine of an angle in 5e-8 degree units
   function automatic void rotate_angle(input longint h, output longint sn,
                                        output longint cs);
      bit neg_cos;
      longint x, y, z, dx, dy;
      longint unsigned m;
      neg_cos = 0;
      if (h > HALF_TURN) h -= FULL_TURN;
      if (h < -HALF_TURN) h += FULL_TURN;
      if (h > QUARTER_TURN) begin
         h = HALF_TURN - h;
         neg_cos = 1;
      end
      if (h < -QUARTER_TURN) begin
         h = -HALF_TURN - h;
         neg_cos = 1;
      end
      m = magnitude(h);
      m = (m * 64'd3373259426 + 64'd1800000000) / 64'd3600000000;
      z = (h < 0) ? -longint'(m) : longint'(m);
      x = CORDIC_START;
      y = 0;
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (z >= 0) begin
            x -= dy; y += dx; z -= arctan_step(i);
         end else begin
            x += dy; y -= dx; z += arctan_step(i);
         end
      end
      if (x > ONE_Q30) x = ONE_Q30;
      if (x < -ONE_Q30) x = -ONE_Q30;
      if (y > ONE_Q30) y = ONE_Q30;
      if (y < -ONE_Q30) y = -ONE_Q30;
      sn = y;
      cs = neg_cos ? -x : x;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // distance to the current target, then advance on arrival
   function automatic wat_rsp_type track_fix(input wat_req_type f);
      wat_rsp_type o;
      longint lat1, lon1, lat2, lon2, s1, s2, c1, c2, junk, a, tx, ty, z, dx, dy;
      longint unsigned c12, t2, span_mm, cnt;
      logic [63:0] w;
      w = waypoint_reg[nav_target];
      lat1 = longint'(f.fix_latitude);
      lon1 = longint'(f.fix_longitude);
      lat2 = longint'($signed(w[63:32]));
      lon2 = longint'($signed(w[31:0]));
      rotate_angle(lat2 - lat1, s1, junk);
      rotate_angle(lon2 - lon1, s2, junk);
      rotate_angle(2 * lat1, junk, c1);
      rotate_angle(2 * lat2, junk, c2);
      c12 = mul_q30(magnitude(c1), magnitude(c2));
      t2 = mul_q30(c12 * longint'(magnitude(s2)), magnitude(s2));
      a = magnitude(s1) * magnitude(s1);
      a = ((c1 < 0) != (c2 < 0)) ? a - longint'(t2) : a + longint'(t2);
      if (a < 0) a = 0;
      if (a > ONE_Q60) a = ONE_Q60;
      ty = longint'(floor_sqrt(a));
      tx = longint'(floor_sqrt(ONE_Q60 - a));
      z = 0;
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
         dx = tx >>> i;
         dy = ty >>> i;
         if (ty > 0) begin
            tx += dy; ty -= dx; z += arctan_step(i);
         end else if (ty < 0) begin
            tx -= dy; ty += dx; z -= arctan_step(i);
         end
      end
      if (z < 0) z = 0;
      if (z > HALF_PI_Q30) z = HALF_PI_Q30;
      span_mm = (longint'(z) * 64'd6371000000 + 64'd268435456) >> 29;
      o.distance_mm = span_mm[DIST_W-1:0];
      o.arrived = (span_mm <= radius_mm);
      o.target_before = nav_target;
      if (o.arrived) begin
         cnt = loop_len;
         if (cnt < 1) cnt = 1;
         if (cnt > MAX_WAYPOINTS) cnt = MAX_WAYPOINTS;
         nav_target = (nav_target + 64'd1 >= cnt) ? 2'd0 : nav_target + 2'd1;
      end
      o.target_after = nav_target;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // register port: setup cycle, then access cycle
   // ---------------------------------------------------------------
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_WAYPOINT_ZERO, REG_WAYPOINT_ONE, REG_WAYPOINT_TWO,
         REG_WAYPOINT_THREE: waypoint_reg[idx[1:0]] = val;
         REG_ACTIVE_WAYPOINTS: loop_len = val[2:0];
         REG_ARRIVAL_RADIUS: radius_mm = val[15:0];
         default: ;
      endcase
   endtask

   // config writes only once the block has gone idle
   task automatic wait_idle;
      while (leg_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // request side: valid held until accepted, random idle bursts between
   // ---------------------------------------------------------------
   task automatic send_fix(input wat_req_type f, input bit typed, input fix_row_type row);
      wat_rsp_type e;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= f;
      do @(posedge clock); while (req_stall);
      e = track_fix(f);
      if (typed && {e.arrived, e.target_before, e.target_after} !=
          {row.arr, row.bef, row.aft}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("predictor disagrees with typed row: lat %0d lon %0d",
                     row.lat, row.lon);
         e.arrived = row.arr;
         e.target_before = row.bef;
         e.target_after = row.aft;
      end
      leg_reports.push_back(e);
      sent++;
   endtask

   task automatic park_sender;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // fix close to the current target, or anywhere
   function automatic wat_req_type pick_fix(input int spread);
      wat_req_type f;
      logic [63:0] w;
      int r;
      w = waypoint_reg[nav_target];
      r = $urandom_range(0, 99);
      if (r < 70) begin
         f.fix_latitude = w[63:32] + $urandom_range(0, 2 * spread) - spread;
         f.fix_longitude = w[31:0] + $urandom_range(0, 2 * spread) - spread;
      end else if (r < 85) begin
         f.fix_latitude = $urandom;
         f.fix_longitude = $urandom;
      end else begin
         f.fix_latitude = int'($urandom_range(0, 32'd3600000000)) - 1800000000;
         f.fix_longitude = int'($urandom_range(0, 32'd3600000000)) - 1800000000;
      end
      return f;
   endfunction

   function automatic logic [63:0] pick_waypoint;
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return {$urandom, $urandom};
         2: return {32'sd900000000, -32'sd1800000000};
         3: return {-32'sd900000000, 32'sd1800000000};
         4: return 64'hFFFF_FFFF_FFFF_FFFF;
         default: return {int'($urandom_range(0, 1800000000)) - 900000000,
                          int'($urandom_range(0, 32'd3600000000)) - 1800000000};
      endcase
   endfunction

   // ---------------------------------------------------------------
   // response side: compare, random stall bursts, one long hold-off
   // ---------------------------------------------------------------
   initial begin : rsp_monitor
      wat_rsp_type e;
      int burst;
      int hold_left;
      burst = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            reports_seen++;
            if (rsp_data.arrived) arrivals_seen++;
            if (leg_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               e = leg_reports.pop_front();
               if (rsp_data.distance_mm !== e.distance_mm ||
                   rsp_data.arrived !== e.arrived ||
                   rsp_data.target_before !== e.target_before ||
                   rsp_data.target_after !== e.target_after) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: expected %p, got %p", e, rsp_data);
               end
            end
         end
         if (hold_pending) begin
            hold_pending = 0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= (hold_left != 0);
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= (burst != 0);
         end else if (quiet_tail || $urandom_range(0, 7) != 0) begin
            rsp_stall <= 1'b0;
         end else begin
            burst = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycles, leg_reports.size());
            $display("waypoint_arrival_tracker_top: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin : stimulus
      wat_req_type f;
      fix_row_type row;
      int per_phase;
      int spread;
      logic [2:0] lens [PHASES] = '{3'd4, 3'd1, 3'd0, 3'd2, 3'd7, 3'd3, 3'd5, 3'd4};
      logic [15:0] radii [PHASES] = '{16'd500, 16'd0, 16'd65535, 16'd2000,
                                      16'd500, 16'd10000, 16'd65535, 16'd1};

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      for (int i = 0; i < 4; i++) waypoint_reg[i] = 64'd0;
      loop_len = 3'd4;
      radius_mm = 16'd500;
      nav_target = 2'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset every waypoint sits at 0,0: the origin arrives each time
      fix_rows = '{
         '{32'sd0, 32'sd0, 1, 1, 2'd0, 2'd1},
         '{32'sd0, 32'sd0, 1, 1, 2'd1, 2'd2},
         '{32'sd0, 32'sd0, 1, 1, 2'd2, 2'd3},
         '{32'sd0, 32'sd0, 1, 1, 2'd3, 2'd0},
         '{32'sd900000000, 32'sd0, 1, 0, 2'd0, 2'd0},
         '{-32'sd900000000, 32'sd0, 1, 0, 2'd0, 2'd0},
         '{32'sd0, 32'sd1800000000, 1, 0, 2'd0, 2'd0},
         '{32'sd0, -32'sd1800000000, 1, 0, 2'd0, 2'd0},
         '{32'sd1800000000, 32'sd1800000000, 0, 0, 2'd0, 2'd0},
         '{-32'sd1800000000, -32'sd1800000000, 0, 0, 2'd0, 2'd0},
         // patterns beyond the coordinate range, then small values near the origin
         '{32'h7FFFFFFF, 32'h80000000, 0, 0, 2'd0, 2'd0},
         '{32'h80000000, 32'h7FFFFFFF, 0, 0, 2'd0, 2'd0},
         '{32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 2'd0, 2'd0},
         '{32'sd20, -32'sd20, 0, 0, 2'd0, 2'd0}
      };
      foreach (fix_rows[i]) begin
         row = fix_rows[i];
         f.fix_latitude = row.lat;
         f.fix_longitude = row.lon;
         send_fix(f, row.known, row);
      end
      park_sender();

      // stale target: walk to index 3, then shrink the loop to 2
      wait_idle();
      while (nav_target != 2'd3) begin
         f = '0;
         send_fix(f, 0, row);
      end
      park_sender();
      wait_idle();
      csr_write(REG_ACTIVE_WAYPOINTS, 64'd2);
      f = '0;
      send_fix(f, 0, row);
      send_fix(f, 0, row);
      park_sender();
      wait_idle();
      csr_write(REG_UNMAPPED, 64'hDEAD_BEEF_0123_4567);

      // random phases, each under its own register setting
      per_phase = RANDOM_ITEMS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         csr_write(REG_WAYPOINT_ZERO, pick_waypoint());
         csr_write(REG_WAYPOINT_ONE, pick_waypoint());
         csr_write(REG_WAYPOINT_TWO, pick_waypoint());
         csr_write(REG_WAYPOINT_THREE, pick_waypoint());
         csr_write(REG_ACTIVE_WAYPOINTS, {61'd0, lens[p]});
         csr_write(REG_ARRIVAL_RADIUS, {48'd0, radii[p]});
         spread = (radii[p] > 16'd5000) ? 8000 : 80;
         if (p == 2) hold_pending = 1;
         for (int n = 0; n < per_phase; n++) begin
            if (p == PHASES - 1 && n >= per_phase - QUIET_TAIL) quiet_tail = 1;
            send_fix(pick_fix(spread), 0, row);
         end
         park_sender();
      end

      while (leg_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d fixes sent, %0d responses checked, %0d arrivals, %0d cycles",
               sent, reports_seen, arrivals_seen, cycles);
      $display("covered: %0d register phases, loop lengths 0 and 7 included, radius 0/65535",
               PHASES);
      if (mismatches == 0) begin
         $display("waypoint_arrival_tracker_top: match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("waypoint_arrival_tracker_top: mismatch");
      end
      $finish;
   end

endmodule
